// File: hw/rtl/text_console_writer_top_defines.svh
// Assertion macros for the text console writer.
// No dependencies; included by text_console_writer_top.sv.
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/tcw_pkg.sv
// Text console writer package: payload structs, command codes, register
// indexes and reset values. No dependencies.
package tcw_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEF_ATTR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK    = 1'b1;

  localparam logic [7:0]  DEF_ATTR_RESET = 8'h02;
  localparam logic [15:0] BLANK_RESET    = 16'h0200;

  localparam logic [2:0] CMD_PRINT       = 3'd0;
  localparam logic [2:0] CMD_PRINT_COLOR = 3'd1;
  localparam logic [2:0] CMD_PRINT_AT    = 3'd2;
  localparam logic [2:0] CMD_ERASE       = 3'd3;
  localparam logic [2:0] CMD_SET_CURSOR  = 3'd4;
  localparam logic [2:0] CMD_READ        = 3'd5;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam int         RESET_ROW    = 19;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] char_code;
    logic [3:0] fg_color;
    logic [2:0] bg_color;
    logic       blink_on;
    logic [6:0] pos_col;
    logic [4:0] pos_row;
  } tcw_in_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [15:0] cell_value;
    logic        scrolled;
    logic        rejected;
  } tcw_out_t;

endpackage

// File: hw/rtl/text_console_writer_top.sv
// Text console writer: cursor, cell store and scroll engine in one module.
// Depends on tcw_pkg and text_console_writer_top_defines.svh.
//
//  channel | ports                           | transfer
//  --------+---------------------------------+---------------------------------
//  input   | start, busy, in_data            | edge with start high, busy low
//  result  | out_valid, out_data             | every edge with out_valid high
//  config  | cfg_we, cfg_index, cfg_wdata    | every edge with cfg_we high
//
// A plain command passes through decode (EXEC), store access (ACCESS)
// and finish (DONE), and the result strobe is registered from DONE; busy
// stays high until the strobe, so a new command waits for the last. A
// command that scrolls adds a sweep in which the scroll engine reads and
// writes back one cell a cycle through the single store port pair. After
// reset a clearing pass zeroes the store; busy stays high meanwhile.
// Results cannot be stalled; the strobe lasts one cycle and busy is already
// low in that cycle, so the next command may transfer alongside it.
`include "text_console_writer_top_defines.svh"

module text_console_writer_top
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  tcw_in_t               in_data,
  output logic                  out_valid,
  output tcw_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int COPY_N = COLUMNS * (ROWS - 1);
  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);
  localparam int AW     = $clog2(CELLS);

  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
  localparam logic [RW-1:0] ROW_RST   = RW'((RESET_ROW < ROWS) ? RESET_ROW : ROWS - 1);
  localparam logic [7:0]    COLS_CMP  = 8'(COLUMNS);
  localparam logic [6:0]    ROWS_CMP  = 7'(ROWS);
  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
  localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_A    = AW'(COPY_N);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_EXEC   = 6'b000100,
    ST_ACCESS = 6'b001000,
    ST_SWEEP  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  tcw_in_t         cmd_r;
  logic [7:0]      def_attr_r;
  logic [15:0]     blank_r;
  logic [CW-1:0]   cur_col_r, col_nxt;
  logic [RW-1:0]   cur_row_r, row_nxt;
  logic [CW-1:0]   tgt_col_r, tgt_col_nxt;
  logic [RW-1:0]   tgt_row_r, tgt_row_nxt;
  logic            wr_r, wr_nxt;
  logic [15:0]     wcell_r, wcell_nxt;
  logic            scroll_r, scroll_nxt;
  logic            rej_r, rej_nxt;
  logic            read_r, read_nxt;
  logic [AW-1:0]   idx_r;
  logic            pw_valid_r;
  logic [AW-1:0]   pw_addr_r;
  logic            pw_blank_r;
  logic            out_valid_r;
  tcw_out_t        out_data_r;

  // cell store
  logic [15:0]     mem [CELLS];
  logic [15:0]     rd_data_r;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr, acc_addr;
  logic [15:0]     mem_wdata;
  logic            copy_cell;

  // decode helpers
  logic            pos_ok;
  logic [CW-1:0]   pos_col_c, base_col, p_col, e_col;
  logic [RW-1:0]   pos_row_c, base_row, p_row, e_row;
  logic            p_nl, p_scroll;
  logic [7:0]      attr;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------
  // Decode: where the command touches the store and where the cursor
  // goes. Print-at runs the plain print at the given spot and keeps
  // the cursor.
  // ---------------------------------------------------------------
  always_comb begin
    pos_col_c = CW'(cmd_r.pos_col);
    pos_row_c = RW'(cmd_r.pos_row);
    pos_ok    = ({1'b0, cmd_r.pos_col} < COLS_CMP) && ({2'b00, cmd_r.pos_row} < ROWS_CMP);

    base_col = cur_col_r;
    base_row = cur_row_r;
    if (cmd_r.command == CMD_PRINT_AT) begin
      base_col = pos_col_c;
      base_row = pos_row_c;
    end

    attr = (cmd_r.command == CMD_PRINT_COLOR) ?
           {cmd_r.blink_on, cmd_r.bg_color, cmd_r.fg_color} : def_attr_r;

    // print: newline or end of line moves down, last row scrolls
    p_nl     = (cmd_r.char_code == NEWLINE_CODE) || (base_col == COL_LAST);
    p_scroll = 1'b0;
    if (p_nl) begin
      p_col = '0;
      if (base_row == ROW_LAST) begin
        p_row    = base_row;
        p_scroll = 1'b1;
      end else begin
        p_row = RW'(base_row + 1'b1);
      end
    end else begin
      p_col = CW'(base_col + 1'b1);
      p_row = base_row;
    end

    // erase: step back, wrapping to the previous row and from the top row
    // to the bottom one
    if (cur_col_r == '0) begin
      e_col = COL_LAST;
      e_row = (cur_row_r == '0) ? ROW_LAST : RW'(cur_row_r - 1'b1);
    end else begin
      e_col = CW'(cur_col_r - 1'b1);
      e_row = cur_row_r;
    end

    tgt_col_nxt = base_col;
    tgt_row_nxt = base_row;
    wr_nxt      = 1'b0;
    wcell_nxt   = {attr, cmd_r.char_code};
    scroll_nxt  = 1'b0;
    rej_nxt     = 1'b0;
    read_nxt    = 1'b0;
    col_nxt     = cur_col_r;
    row_nxt     = cur_row_r;

    unique case (cmd_r.command) inside
      CMD_PRINT, CMD_PRINT_COLOR: begin
        wr_nxt     = (cmd_r.char_code != NEWLINE_CODE);
        scroll_nxt = p_scroll;
        col_nxt    = p_col;
        row_nxt    = p_row;
      end
      CMD_PRINT_AT: begin
        if (pos_ok) begin
          wr_nxt     = (cmd_r.char_code != NEWLINE_CODE);
          scroll_nxt = p_scroll;
        end else begin
          rej_nxt = 1'b1;
        end
      end
      CMD_ERASE: begin
        wr_nxt      = 1'b1;
        wcell_nxt   = blank_r;
        tgt_col_nxt = e_col;
        tgt_row_nxt = e_row;
        col_nxt     = e_col;
        row_nxt     = e_row;
      end
      CMD_SET_CURSOR: begin
        if (pos_ok) begin
          col_nxt = pos_col_c;
          row_nxt = pos_row_c;
        end else begin
          rej_nxt = 1'b1;
        end
      end
      CMD_READ: begin
        if (pos_ok) begin
          read_nxt    = 1'b1;
          tgt_col_nxt = pos_col_c;
          tgt_row_nxt = pos_row_c;
        end else begin
          rej_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------
  // Store ports. Scroll copies cell idx+COLUMNS down to idx; the write
  // follows its read in the next cycle. Sources always lie above the write
  // pointer, so no read sees a stale entry.
  // ---------------------------------------------------------------
  assign acc_addr  = AW'(AW'(tgt_row_r) * COLS_A) + AW'(tgt_col_r);
  assign copy_cell = (idx_r < COPY_A);

  always_comb begin
    mem_raddr = acc_addr;
    if (state_r == ST_SWEEP) begin
      mem_raddr = copy_cell ? AW'(idx_r + COLS_A) : idx_r;
    end

    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = '0;
    if (pw_valid_r) begin
      mem_we    = 1'b1;
      mem_waddr = pw_addr_r;
      mem_wdata = pw_blank_r ? blank_r : rd_data_r;
    end else if ((state_r == ST_ACCESS) && wr_r) begin
      mem_we    = 1'b1;
      mem_waddr = acc_addr;
      mem_wdata = wcell_r;
    end else if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // ---------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (idx_r == CELL_LAST) state_nxt = ST_IDLE;
      ST_IDLE:   if (start) state_nxt = ST_EXEC;
      ST_EXEC:   state_nxt = ST_ACCESS;
      ST_ACCESS: state_nxt = scroll_r ? ST_SWEEP : ST_DONE;
      ST_SWEEP:  if (idx_r == CELL_LAST) state_nxt = ST_DONE;
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      def_attr_r  <= DEF_ATTR_RESET;
      blank_r     <= BLANK_RESET;
      cur_col_r   <= '0;
      cur_row_r   <= ROW_RST;
      idx_r       <= '0;
      pw_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pw_valid_r  <= (state_r == ST_SWEEP);
      out_valid_r <= (state_r == ST_DONE);

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DEF_ATTR: def_attr_r <= cfg_wdata[7:0];
          CFG_BLANK:    blank_r    <= cfg_wdata;
          default: begin
          end
        endcase
      end

      if (state_r == ST_EXEC) begin
        cur_col_r <= col_nxt;
        cur_row_r <= row_nxt;
      end

      if ((state_r == ST_CLEAR) || (state_r == ST_SWEEP)) begin
        idx_r <= (idx_r == CELL_LAST) ? '0 : AW'(idx_r + 1'b1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && start) begin
      cmd_r <= in_data;
    end
    if (state_r == ST_EXEC) begin
      tgt_col_r <= tgt_col_nxt;
      tgt_row_r <= tgt_row_nxt;
      wr_r      <= wr_nxt;
      wcell_r   <= wcell_nxt;
      scroll_r  <= scroll_nxt;
      rej_r     <= rej_nxt;
      read_r    <= read_nxt;
    end
    pw_addr_r  <= idx_r;
    pw_blank_r <= !copy_cell;
    if (state_r == ST_DONE) begin
      out_data_r.cursor_col <= 7'(cur_col_r);
      out_data_r.cursor_row <= 5'(cur_row_r);
      out_data_r.cell_value <= read_r ? rd_data_r : '0;
      out_data_r.scrolled   <= scroll_r;
      out_data_r.rejected   <= rej_r;
    end
  end

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  `TCW_ASSERT_NEXT(a_accept_decodes, start && !busy, state_r == ST_EXEC,
                   "accepted command did not enter decode")
  `TCW_ASSERT_NOW(a_strobe_idle, out_valid_r, state_r == ST_IDLE,
                  "result strobe outside idle")
  `TCW_ASSERT_NOW(a_cursor_range, 1'b1, (cur_col_r <= COL_LAST) && (cur_row_r <= ROW_LAST),
                  "cursor out of screen")
  `TCW_ASSERT_NOW(a_scroll_write, pw_valid_r, (state_r == ST_SWEEP) || (state_r == ST_DONE),
                  "scroll write-back outside scroll")

endmodule

// File: tb/text_console_writer_checker.sv
// Checker for the text console writer: watches the command, result and
// register ports, predicts each result and compares it field by field.
// Depends on tcw_pkg.
module text_console_writer_checker
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  tcw_in_t               in_data,
  input  logic                  out_valid,
  input  tcw_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_cnt,
  output int                    pending_cnt,
  output int                    result_cnt,
  output int                    scroll_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PRINTED = 100;

  logic [15:0] screen [COLUMNS*ROWS];
  int unsigned cur_col;
  int unsigned cur_row;
  logic [7:0]  attr_q;
  logic [15:0] blank_q;
  tcw_out_t    pending_q[$];

  task automatic report_mismatch(input string msg);
    if (fail_cnt < MAX_PRINTED)
      $display("[%0t] ERROR %s", $time, msg);
    fail_cnt++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d: %s is 0x%0h, predicted 0x%0h",
                                result_cnt, name, got, want));
  endtask

  function automatic void scroll_up();
    for (int i = 0; i < COLUMNS*(ROWS-1); i++)
      screen[i] = screen[i+COLUMNS];
    for (int i = 0; i < COLUMNS; i++)
      screen[(ROWS-1)*COLUMNS + i] = blank_q;
  endfunction

  function automatic bit next_line();
    cur_col = 0;
    if (cur_row + 1 >= ROWS) begin
      scroll_up();
      return 1'b1;
    end
    cur_row++;
    return 1'b0;
  endfunction

  function automatic bit put_glyph(input logic [7:0] ch, input logic [7:0] attr);
    if (ch == NEWLINE_CODE)
      return next_line();
    screen[cur_row*COLUMNS + cur_col] = {attr, ch};
    cur_col++;
    if (cur_col >= COLUMNS)
      return next_line();
    return 1'b0;
  endfunction

  function automatic tcw_out_t predict_console(input tcw_in_t c);
    tcw_out_t    r;
    bit          pos_ok;
    int unsigned keep_col;
    int unsigned keep_row;
    r = '0;
    pos_ok = (c.pos_col < COLUMNS) && (c.pos_row < ROWS);
    case (c.command)
      CMD_PRINT: r.scrolled = put_glyph(c.char_code, attr_q);
      CMD_PRINT_COLOR:
        r.scrolled = put_glyph(c.char_code, {c.blink_on, c.bg_color, c.fg_color});
      CMD_PRINT_AT: begin
        if (!pos_ok) begin
          r.rejected = 1'b1;
        end else begin
          keep_col = cur_col;
          keep_row = cur_row;
          cur_col = 32'(c.pos_col);
          cur_row = 32'(c.pos_row);
          r.scrolled = put_glyph(c.char_code, attr_q);
          cur_col = keep_col;
          cur_row = keep_row;
        end
      end
      CMD_ERASE: begin
        // column 0 steps back to the end of the previous row, row 0 wraps
        if (cur_col == 0) begin
          cur_col = COLUMNS - 1;
          cur_row = (cur_row == 0) ? ROWS - 1 : cur_row - 1;
        end else begin
          cur_col--;
        end
        screen[cur_row*COLUMNS + cur_col] = blank_q;
      end
      CMD_SET_CURSOR: begin
        if (!pos_ok) begin
          r.rejected = 1'b1;
        end else begin
          cur_col = 32'(c.pos_col);
          cur_row = 32'(c.pos_row);
        end
      end
      CMD_READ: begin
        if (!pos_ok)
          r.rejected = 1'b1;
        else
          r.cell_value = screen[c.pos_row*COLUMNS + c.pos_col];
      end
      default: ;
    endcase
    r.cursor_col = cur_col[6:0];
    r.cursor_row = cur_row[4:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    tcw_out_t want;
    if (!rst_n) begin
      foreach (screen[i]) screen[i] = '0;
      cur_col = 0;
      cur_row = (RESET_ROW < ROWS) ? RESET_ROW : ROWS - 1;
      attr_q = DEF_ATTR_RESET;
      blank_q = BLANK_RESET;
      pending_q.delete();
      fail_cnt = 0;
      result_cnt = 0;
      scroll_cnt = 0;
    end else begin
      // results first: the strobe may share an edge with the next transfer
      if (out_valid) begin
        result_cnt++;
        if (pending_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no command outstanding",
                                    result_cnt));
        end else begin
          want = pending_q.pop_front();
          check_field("cursor_col", 16'(out_data.cursor_col), 16'(want.cursor_col));
          check_field("cursor_row", 16'(out_data.cursor_row), 16'(want.cursor_row));
          check_field("cell_value", out_data.cell_value, want.cell_value);
          check_field("scrolled", 16'(out_data.scrolled), 16'(want.scrolled));
          check_field("rejected", 16'(out_data.rejected), 16'(want.rejected));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEF_ATTR: attr_q = cfg_wdata[7:0];
          CFG_BLANK:    blank_q = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        want = predict_console(in_data);
        if (want.scrolled)
          scroll_cnt++;
        pending_q.push_back(want);
      end
    end
    pending_cnt = pending_q.size();
  end

endmodule

// File: tb/text_console_writer_top_tb.sv
// Testbench top for the text console writer: clock, reset, command and
// register stimulus, and the verdict. Depends on tcw_pkg, the block and
// text_console_writer_checker.
module text_console_writer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int COLS          = 80;
  localparam int NROWS         = 25;
  localparam int LAST_COL      = COLS - 1;
  localparam int LAST_ROW      = NROWS - 1;
  localparam int SETTLE_CYCLES = 16;   // idle time after the last result comes back

  // codes the block decodes as no-ops
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  tcw_in_t               in_data;
  logic                  out_valid;
  tcw_out_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_cnt;
  int pending_cnt;
  int result_cnt;
  int scroll_cnt;

  int sent_cnt;      // commands transferred so far
  int directed_cnt;
  int gap_pct;       // chance per cycle that the sender holds off

  always #5 clk = ~clk;

  text_console_writer_top #(
    .COLUMNS(COLS),
    .ROWS   (NROWS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  text_console_writer_checker #(
    .COLUMNS(COLS),
    .ROWS   (NROWS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_cnt   (fail_cnt),
    .pending_cnt(pending_cnt),
    .result_cnt (result_cnt),
    .scroll_cnt (scroll_cnt)
  );

  // Fully random command word, every bit of every field.
  function automatic tcw_in_t junk_word();
    logic [31:0] r;
    tcw_in_t     w;
    r = $urandom;
    w = r[$bits(tcw_in_t)-1:0];
    return w;
  endfunction

  // Command with the given opcode, character and position; the colour
  // fields stay random since only the colour print looks at them.
  function automatic tcw_in_t cmd_word(input logic [2:0] op, input logic [7:0] ch,
                                       input int col, input int row);
    tcw_in_t w;
    w = junk_word();
    w.command = op;
    w.char_code = ch;
    w.pos_col = col[6:0];
    w.pos_row = row[4:0];
    return w;
  endfunction

  // Random bytes with an occasional forced line feed.
  function automatic logic [7:0] rand_char();
    logic [7:0] ch;
    ch = 8'($urandom);
    if ($urandom_range(23) == 0)
      ch = NEWLINE_CODE;
    return ch;
  endfunction

  // One command transfer. start is raised in the step after the previous
  // transfer (or kept high), so start never sees two updates in one step.
  // The transfer lands on the first edge with busy low; the sender may
  // then back off for a random number of cycles with junk on in_data.
  task automatic send(input tcw_in_t w);
    start <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_cnt++;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      do begin
        in_data <= junk_word();
        @(posedge clk);
      end while ($urandom_range(99) < gap_pct);
    end
  endtask

  // Hold off until every predicted result has come back, then let the
  // block settle. Pending count is sampled at the falling edge so the
  // checker's update at the rising edge has already happened.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending_cnt != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers, back to back; only called with the block idle.
  // Upper byte of the attribute write is random: the block keeps 8 bits.
  task automatic program_regs(input logic [7:0] attr, input logic [15:0] blank);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DEF_ATTR;
    cfg_wdata <= {8'($urandom), attr};
    @(posedge clk);
    cfg_index <= CFG_BLANK;
    cfg_wdata <= blank;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Park the cursor somewhere, print a short run, maybe erase, then read
  // the run back. Read positions wrap row by row and from the bottom row to the top.
  task automatic write_then_read();
    int row;
    int col;
    int n;
    int p;
    row = ($urandom_range(9) == 0) ? LAST_ROW : $urandom_range(LAST_ROW);
    col = $urandom_range(LAST_COL);
    n = $urandom_range(1, 8);
    send(cmd_word(CMD_SET_CURSOR, 8'($urandom), col, row));
    for (int i = 0; i < n; i++)
      send(cmd_word(($urandom_range(1) != 0) ? CMD_PRINT_COLOR : CMD_PRINT,
                    rand_char(), $urandom, $urandom));
    if ($urandom_range(3) == 0)
      send(cmd_word(CMD_ERASE, 8'($urandom), $urandom, $urandom));
    for (int i = 0; i < n; i++) begin
      p = row*COLS + col + i;
      send(cmd_word(CMD_READ, 8'($urandom), p % COLS, (p / COLS) % NROWS));
    end
  endtask

  // Print at an arbitrary cell without moving the cursor, read it back.
  task automatic print_at_then_read();
    int row;
    int col;
    row = $urandom_range(LAST_ROW);
    col = $urandom_range(LAST_COL);
    send(cmd_word(CMD_PRINT_AT, rand_char(), col, row));
    send(cmd_word(CMD_READ, 8'($urandom), col, row));
  endtask

  // Line feed on the bottom row forces a scroll; then look at the freshly
  // blanked bottom row and the row that moved up.
  task automatic scroll_probe();
    int col;
    col = $urandom_range(LAST_COL);
    send(cmd_word(CMD_SET_CURSOR, 8'($urandom), col, LAST_ROW));
    send(cmd_word(CMD_PRINT, NEWLINE_CODE, $urandom, $urandom));
    send(cmd_word(CMD_READ, 8'($urandom), $urandom_range(LAST_COL), LAST_ROW));
    send(cmd_word(CMD_READ, 8'($urandom), col, LAST_ROW - 1));
  endtask

  // Random part of one register setting: mostly well-formed write/read
  // sequences, the rest fully random commands (out-of-range positions,
  // spare opcodes, erase from anywhere).
  task automatic run_phase(input int quota, input int idle_pct);
    int stop_at;
    int pick;
    gap_pct = idle_pct;
    stop_at = sent_cnt + quota;
    while (sent_cnt < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55)
        write_then_read();
      else if (pick < 65)
        print_at_then_read();
      else if (pick < 70)
        scroll_probe();
      else
        send(junk_word());
    end
  endtask

  initial begin : stimulus
    tcw_in_t w;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_DEF_ATTR;
    cfg_wdata = '0;
    sent_cnt = 0;
    gap_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, registers at their reset values. The first transfer
    // waits out the clearing pass through busy.
    send(cmd_word(CMD_READ, 8'h00, 0, 0));              // cleared store
    send(cmd_word(CMD_READ, 8'hFF, LAST_COL, LAST_ROW));
    send(cmd_word(CMD_PRINT, 8'h00, 0, 0));             // cursor starts on row 19
    send(cmd_word(CMD_PRINT, 8'hFF, 127, 31));
    w = cmd_word(CMD_PRINT_COLOR, 8'h41, 0, 0);
    w.fg_color = 4'hF;
    w.bg_color = 3'h7;
    w.blink_on = 1'b1;
    send(w);
    w = cmd_word(CMD_PRINT_COLOR, 8'h7F, 0, 0);
    w.fg_color = 4'h0;
    w.bg_color = 3'h0;
    w.blink_on = 1'b0;
    send(w);
    send(cmd_word(CMD_PRINT, NEWLINE_CODE, 0, 0));
    send(cmd_word(CMD_PRINT_COLOR, NEWLINE_CODE, 0, 0));
    for (int i = 0; i < 3; i++)
      send(cmd_word(CMD_READ, 8'h00, i, RESET_ROW));
    // wrap off the last cell scrolls; so does a line feed on the bottom row
    send(cmd_word(CMD_SET_CURSOR, 8'h00, LAST_COL, LAST_ROW));
    send(cmd_word(CMD_PRINT, 8'h5A, 0, 0));
    send(cmd_word(CMD_READ, 8'h00, LAST_COL, LAST_ROW - 1));
    send(cmd_word(CMD_PRINT, NEWLINE_CODE, 0, 0));
    // print at position scrolls too but leaves the cursor alone
    send(cmd_word(CMD_PRINT_AT, 8'h71, LAST_COL, LAST_ROW));
    send(cmd_word(CMD_PRINT_AT, NEWLINE_CODE, 5, LAST_ROW));
    send(cmd_word(CMD_PRINT_AT, 8'h21, COLS, 0));       // rejected
    send(cmd_word(CMD_PRINT_AT, 8'h21, 0, NROWS));      // rejected
    // erase from the home position wraps to the last cell of the screen
    send(cmd_word(CMD_SET_CURSOR, 8'h00, 0, 0));
    send(cmd_word(CMD_ERASE, 8'h00, 0, 0));
    send(cmd_word(CMD_ERASE, 8'h00, 0, 0));
    send(cmd_word(CMD_READ, 8'h00, LAST_COL, LAST_ROW));
    send(cmd_word(CMD_SET_CURSOR, 8'h00, COLS, 3));     // rejected
    send(cmd_word(CMD_SET_CURSOR, 8'h00, 0, 31));       // rejected
    send(cmd_word(CMD_READ, 8'h00, 0, NROWS));          // rejected
    send(cmd_word(CMD_READ, 8'h00, 127, 0));            // rejected
    send(cmd_word(CMD_SPARE_A, 8'h00, 0, 0));
    send(cmd_word(CMD_SPARE_B, 8'h00, 0, 0));
    directed_cnt = sent_cnt;
    drain();

    // Random part over three register settings: both extremes, then a
    // random one. Sender idling rises, then stops in the last phase; each drain
    // holds the sender until every result is back.
    program_regs(8'h00, 16'h0000);
    run_phase(520, 33);
    drain();
    program_regs(8'hFF, 16'hFFFF);
    run_phase(520, 59);
    drain();
    program_regs(8'($urandom), 16'($urandom));
    run_phase(510, 0);
    drain();

    $display("Ran %0d commands (%0d directed) under reset, zero, all-ones and random",
             sent_cnt, directed_cnt);
    $display("register settings; %0d results checked, %0d of them scrolled the screen",
             result_cnt, scroll_cnt);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("text_console_writer_top: match");
    end else begin
      $display("text_console_writer_top: mismatch");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest expected run, even if every
  // command scrolled.
  initial begin : watchdog
    #200ms;
    $display("text_console_writer_top: mismatch");
    $finish;
  end

endmodule
